// ===== design/key_code_remap_table_unit_macros.svh =====
// Assertion macros for the key code remap table checker.
// No dependencies; included by files that carry assertions.
`ifndef KEY_CODE_REMAP_TABLE_UNIT_MACROS_SVH
`define KEY_CODE_REMAP_TABLE_UNIT_MACROS_SVH

// Clocked property, disabled during reset.
`define KCRT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold.
`define KCRT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `KCRT_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== design/kcrt_pkg.sv =====
// Shared types and constants for the key code remap table.
// No dependencies.
package kcrt_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int NUM_DEFAULTS = 4;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_IDX_W    = $clog2(NUM_DEFAULTS);
    localparam int CFG_W        = 35;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [15:0] src_code;
        logic [1:0]  new_type;
        logic [15:0] new_dst;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  out_type;
        logic [15:0] out_code;
        logic [4:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic [15:0] src;
        logic [1:0]  typ;
        logic [15:0] dst;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t ent;
    } dflt_t;

    typedef struct packed {
        logic load;
        logic search;
        logic exec;
    } ctrl_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MATCH = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

endpackage

// ===== design/key_code_remap_table_unit.sv =====
// Key code remap table: an accepted start runs the controller's search, update
// and respond sequence, with done raised in the respond state; no new operation
// is taken until it ends, and busy stays high until the result cycle ends.
// Reset empties the custom table and marks all default entries invalid.
// Results show for one cycle with done; the receiver cannot stall.
module key_code_remap_table_unit
    import kcrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    output logic                 done,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t cmd;

    kcrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    kcrt_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

// ===== design/kcrt_ctrl.sv =====
// Sequencing controller for the key code remap table.
// Depends on kcrt_pkg.
module kcrt_ctrl
    import kcrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_RESP;
            ST_RESP:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_RESP);
    assign cmd.load   = start && (state_reg == ST_IDLE);
    assign cmd.search = (state_reg == ST_MATCH);
    assign cmd.exec   = (state_reg == ST_EXEC);

endmodule

// ===== design/kcrt_datapath.sv =====
// Table storage, match logic and result register of the key code remap table.
// Depends on kcrt_pkg.
module kcrt_datapath
    import kcrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    input  req_t                 req,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    output rsp_t                 rsp
);

    req_t             op_reg;
    entry_t           ent_reg  [TABLE_DEPTH];
    entry_t           ent_next [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    dflt_t            dflt_reg [NUM_DEFAULTS];

    logic             hit_reg;
    logic             hit_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_idx_next;
    logic             def_hit_reg;
    logic             def_hit_next;
    entry_t           def_ent_reg;
    entry_t           def_ent_next;

    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic [CNT_W+4:0] count_wide;
    entry_t           new_ent;
    entry_t           hit_ent;

    // search: first custom match and first valid default match
    always_comb
    begin
        hit_next     = 1'b0;
        hit_idx_next = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < count_reg) && (ent_reg[i].src == op_reg.src_code))
            begin
                hit_next     = 1'b1;
                hit_idx_next = IDX_W'(i);
            end
        end
        def_hit_next = 1'b0;
        def_ent_next = dflt_reg[0].ent;
        for (int j = NUM_DEFAULTS - 1; j >= 0; j--)
        begin
            if (dflt_reg[j].valid && (dflt_reg[j].ent.src == op_reg.src_code))
            begin
                def_hit_next = 1'b1;
                def_ent_next = dflt_reg[j].ent;
            end
        end
    end

    assign new_ent = '{src: op_reg.src_code, typ: op_reg.new_type, dst: op_reg.new_dst};
    assign hit_ent = ent_reg[hit_idx_reg];

    // execute: table update and result
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        count_next = count_reg;
        rsp_next   = '0;
        unique case (op_reg.opcode)
            OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    rsp_next.ok       = 1'b1;
                    rsp_next.out_type = hit_ent.typ;
                    rsp_next.out_code = hit_ent.dst;
                end
                else if (def_hit_reg)
                begin
                    rsp_next.ok       = 1'b1;
                    rsp_next.out_type = def_ent_reg.typ;
                    rsp_next.out_code = def_ent_reg.dst;
                end
                else
                begin
                    rsp_next.out_code = op_reg.src_code;
                end
            end
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    ent_next[hit_idx_reg] = new_ent;
                    rsp_next.ok           = 1'b1;
                end
                else if (count_reg < CNT_W'(TABLE_DEPTH))
                begin
                    ent_next[count_reg[IDX_W-1:0]] = new_ent;
                    count_next                     = count_reg + CNT_W'(1);
                    rsp_next.ok                    = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (hit_reg)
                begin
                    for (int i = 0; i < TABLE_DEPTH - 1; i++)
                    begin
                        if (IDX_W'(i) >= hit_idx_reg)
                        begin
                            ent_next[i] = ent_reg[i + 1];
                        end
                    end
                    count_next  = count_reg - CNT_W'(1);
                    rsp_next.ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next  = '0;
                rsp_next.ok = 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        count_wide           = (CNT_W + 5)'(count_next);
        rsp_next.entry_count = count_wide[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int j = 0; j < NUM_DEFAULTS; j++)
            begin
                dflt_reg[j] <= '0;
            end
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                dflt_reg[cfg_idx] <= dflt_t'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req;
        end
        if (cmd.search)
        begin
            hit_reg     <= hit_next;
            hit_idx_reg <= hit_idx_next;
            def_hit_reg <= def_hit_next;
            def_ent_reg <= def_ent_next;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                ent_reg[i] <= ent_next[i];
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== design/kcrt_checker.sv =====
// Port-level checker for the key code remap table, bound to the top level.
// Depends on kcrt_pkg and key_code_remap_table_unit_macros.svh.
`include "key_code_remap_table_unit_macros.svh"

module kcrt_checker
    import kcrt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    `KCRT_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "busy not raised after transfer")
    `KCRT_ASSERT(a_latency, clk, rst_n, (start && !busy) |-> ##3 done, "result not on time")
    `KCRT_ASSERT(a_done_pulse, clk, rst_n, done |=> !done, "done longer than one cycle")
    `KCRT_ASSERT_NEVER(a_done_idle, clk, rst_n, done && !busy, "done while idle")
    `KCRT_ASSERT_NEVER(a_count_range, clk, rst_n, done && (rsp.entry_count > 5'(TABLE_DEPTH)), "entry count too large")

endmodule

bind key_code_remap_table_unit kcrt_checker u_kcrt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
